[design/mstk_pkg.sv]
// ----------------------------------------------------------------------------
// mstk_pkg
// Shared types and sizing for the partitioned multi-stack: command codes,
// status codes, the queued command record and the derived widths.
// ----------------------------------------------------------------------------
package mstk_pkg;

    // sizing
    localparam int TOTAL_DEPTH = 256;
    localparam int NUM_STACKS  = 4;
    localparam int DATA_W      = 32;
    localparam int CAP         = TOTAL_DEPTH / NUM_STACKS;

    // port field widths
    localparam int KIND_W   = 2;
    localparam int IDX_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // derived widths
    localparam int ADDR_W = (TOTAL_DEPTH > 1) ? $clog2(TOTAL_DEPTH) : 1;
    localparam int SEL_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int CNT_W  = (CAP > 0) ? $clog2(CAP + 1) : 1;

    // command queue depth
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // request kinds as they arrive on the port
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH = 2'd0,
        KIND_POP  = 2'd1,
        KIND_PEEK = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    // classified operations handed to the back end
    typedef enum logic [2:0] {
        OP_PUSH      = 3'd0,
        OP_POP       = 3'd1,
        OP_PEEK      = 3'd2,
        OP_NOP       = 3'd3,
        OP_BAD_PUSH  = 3'd4,
        OP_BAD_READ  = 3'd5,
        OP_BAD_NOP   = 3'd6
    } t_op;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } t_status;

    // one queued command
    typedef struct packed {
        t_op               op;
        logic [SEL_W-1:0]  sel;
        logic [DATA_W-1:0] value;
    } t_cmd;

endpackage

[design/mstk_queue.sv]
// ----------------------------------------------------------------------------
// mstk_queue
// Short command queue between the front end and the back end. Write and
// read may happen in the same cycle.
// ----------------------------------------------------------------------------
module mstk_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  mstk_pkg::t_cmd  i_wr_cmd,
    input  logic            i_rd,
    output mstk_pkg::t_cmd  o_head,
    output logic            o_valid,
    output logic            o_full
);

    mstk_pkg::t_cmd                r_entry [mstk_pkg::Q_DEPTH];
    logic [mstk_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [mstk_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [mstk_pkg::QCNT_W-1:0]   r_count;
    logic                          wr_en;
    logic                          rd_en;

    assign o_full  = (r_count == mstk_pkg::QCNT_W'(mstk_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_entry[r_rd_ptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && o_valid;

    // storage; no reset needed on payload
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_entry[r_wr_ptr] <= i_wr_cmd;
        end
    end

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + mstk_pkg::QPTR_W'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + mstk_pkg::QPTR_W'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + mstk_pkg::QCNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - mstk_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

[design/mstk_front.sv]
// ----------------------------------------------------------------------------
// mstk_front
// Request intake: takes an item on start, checks the stack index and the
// kind, and turns it into a command for the queue.
// ----------------------------------------------------------------------------
module mstk_front (
    input  logic                          start,
    output logic                          busy,
    input  logic [mstk_pkg::KIND_W-1:0]   i_kind,
    input  logic [mstk_pkg::IDX_W-1:0]    i_stack_index,
    input  logic [mstk_pkg::VALUE_W-1:0]  i_push_value,
    input  logic                          i_q_full,
    output logic                          o_q_wr,
    output mstk_pkg::t_cmd                o_q_cmd
);

    logic            idx_ok;
    mstk_pkg::t_kind kind;

    assign busy   = i_q_full;
    assign o_q_wr = start && !i_q_full;
    assign kind   = mstk_pkg::t_kind'(i_kind);
    assign idx_ok = (32'(i_stack_index) < mstk_pkg::NUM_STACKS);

    // classify: an index past the last stack never touches state
    always_comb begin
        o_q_cmd.sel   = mstk_pkg::SEL_W'(i_stack_index);
        o_q_cmd.value = mstk_pkg::DATA_W'(i_push_value);
        case (kind)
            mstk_pkg::KIND_PUSH: begin
                o_q_cmd.op = idx_ok ? mstk_pkg::OP_PUSH : mstk_pkg::OP_BAD_PUSH;
            end
            mstk_pkg::KIND_POP: begin
                o_q_cmd.op = idx_ok ? mstk_pkg::OP_POP : mstk_pkg::OP_BAD_READ;
            end
            mstk_pkg::KIND_PEEK: begin
                o_q_cmd.op = idx_ok ? mstk_pkg::OP_PEEK : mstk_pkg::OP_BAD_READ;
            end
            default: begin
                o_q_cmd.op = idx_ok ? mstk_pkg::OP_NOP : mstk_pkg::OP_BAD_NOP;
            end
        endcase
    end

endmodule

[design/mstk_back.sv]
// ----------------------------------------------------------------------------
// mstk_back
// Execution side: holds the fill counts and the shared stack memory, runs
// one queued command at a time and drives the registered result.
// ----------------------------------------------------------------------------
module mstk_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  mstk_pkg::t_cmd                 i_q_head,
    output logic                           o_q_rd,
    output logic                           o_done,
    output logic [mstk_pkg::VALUE_W-1:0]   o_read_value,
    output logic [mstk_pkg::STATUS_W-1:0]  o_status,
    output logic                           o_now_empty
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state                         r_state, n_state;
    logic                           r_done, n_done;
    logic [mstk_pkg::VALUE_W-1:0]   r_value, n_value;
    mstk_pkg::t_status              r_status, n_status;
    logic                           r_empty, n_empty;
    logic [mstk_pkg::CNT_W-1:0]     r_fill [mstk_pkg::NUM_STACKS];
    logic [mstk_pkg::CNT_W-1:0]     n_cnt;
    logic                           fill_we;

    logic [mstk_pkg::DATA_W-1:0]    r_mem [mstk_pkg::TOTAL_DEPTH];
    logic [mstk_pkg::DATA_W-1:0]    r_mem_q;
    logic                           mem_we;
    logic                           mem_re;
    logic [mstk_pkg::ADDR_W-1:0]    mem_addr;
    logic [mstk_pkg::ADDR_W-1:0]    wr_addr;
    logic [mstk_pkg::ADDR_W-1:0]    rd_addr;
    logic [mstk_pkg::CNT_W-1:0]     cnt;

    // current count and the two candidate addresses (base + count, top)
    assign cnt      = r_fill[i_q_head.sel];
    assign wr_addr  = mstk_pkg::ADDR_W'(32'(i_q_head.sel) * mstk_pkg::CAP + 32'(cnt));
    assign rd_addr  = wr_addr - mstk_pkg::ADDR_W'(1);
    assign mem_addr = mem_we ? wr_addr : rd_addr;

    // command execution
    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_value  = r_value;
        n_status = r_status;
        n_empty  = r_empty;
        n_cnt    = cnt;
        fill_we  = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        o_q_rd   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_rd   = 1'b1;
                    n_done   = 1'b1;
                    n_value  = '0;
                    n_status = mstk_pkg::ST_OK;
                    n_empty  = 1'b1;
                    case (i_q_head.op)
                        mstk_pkg::OP_PUSH: begin
                            if (32'(cnt) < mstk_pkg::CAP) begin
                                mem_we  = 1'b1;
                                fill_we = 1'b1;
                                n_cnt   = cnt + mstk_pkg::CNT_W'(1);
                                n_empty = 1'b0;
                            end else begin
                                n_status = mstk_pkg::ST_OVER;
                                n_empty  = (cnt == '0);
                            end
                        end
                        mstk_pkg::OP_POP, mstk_pkg::OP_PEEK: begin
                            if (cnt != '0) begin
                                // read data lands next cycle
                                mem_re  = 1'b1;
                                n_done  = 1'b0;
                                n_state = S_READ;
                                if (i_q_head.op == mstk_pkg::OP_POP) begin
                                    fill_we = 1'b1;
                                    n_cnt   = cnt - mstk_pkg::CNT_W'(1);
                                    n_empty = (cnt == mstk_pkg::CNT_W'(1));
                                end else begin
                                    n_empty = 1'b0;
                                end
                            end else begin
                                n_status = mstk_pkg::ST_UNDER;
                            end
                        end
                        mstk_pkg::OP_NOP: begin
                            n_empty = (cnt == '0);
                        end
                        mstk_pkg::OP_BAD_PUSH: begin
                            n_status = mstk_pkg::ST_OVER;
                        end
                        mstk_pkg::OP_BAD_READ: begin
                            n_status = mstk_pkg::ST_UNDER;
                        end
                        default: begin
                            n_status = mstk_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_done  = 1'b1;
                n_value = mstk_pkg::VALUE_W'(r_mem_q);
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // stack memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= i_q_head.value;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_addr];
        end
    end

    // control state and fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            for (int i = 0; i < mstk_pkg::NUM_STACKS; i++) begin
                r_fill[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (fill_we) begin
                r_fill[i_q_head.sel] <= n_cnt;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_status <= n_status;
        r_empty  <= n_empty;
    end

    assign o_done       = r_done;
    assign o_read_value = r_value;
    assign o_status     = r_status;
    assign o_now_empty  = r_empty;

endmodule

[design/partitioned_multi_stack.sv]
// ----------------------------------------------------------------------------
// partitioned_multi_stack
// Four fixed-size stacks sharing one 256-word memory. A push, pop or peek
// request is classified on entry, queued, and executed by the back end.
// Push, no-op and error items are strobed from the back end's result registers;
// a pop or peek that reads the memory goes through the S_READ state first.
// Throughput: one item per cycle for push-type items while busy is low; a reading
// pop or peek holds the back end in S_READ, set by the registered memory read port.
// Reset clears fill counts, queue and control; memory contents are kept.
// The receiver cannot stall: each result is shown for one cycle on o_done.
// ----------------------------------------------------------------------------
module partitioned_multi_stack (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [mstk_pkg::KIND_W-1:0]    i_kind,
    input  logic [mstk_pkg::IDX_W-1:0]     i_stack_index,
    input  logic [mstk_pkg::VALUE_W-1:0]   i_push_value,
    output logic                           o_done,
    output logic [mstk_pkg::VALUE_W-1:0]   o_read_value,
    output logic [mstk_pkg::STATUS_W-1:0]  o_status,
    output logic                           o_now_empty
);

    logic           q_wr;
    logic           q_rd;
    logic           q_full;
    logic           q_valid;
    mstk_pkg::t_cmd q_wr_cmd;
    mstk_pkg::t_cmd q_head;

    // intake and classification
    mstk_front u_front (
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_stack_index (i_stack_index),
        .i_push_value  (i_push_value),
        .i_q_full      (q_full),
        .o_q_wr        (q_wr),
        .o_q_cmd       (q_wr_cmd)
    );

    // command queue
    mstk_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (q_wr),
        .i_wr_cmd (q_wr_cmd),
        .i_rd     (q_rd),
        .o_head   (q_head),
        .o_valid  (q_valid),
        .o_full   (q_full)
    );

    // execution
    mstk_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_head     (q_head),
        .o_q_rd       (q_rd),
        .o_done       (o_done),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_now_empty  (o_now_empty)
    );

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the partitioned multi-stack. A short table of
// requests covers empty-stack reads, no-ops and extreme data words. After it,
// random bursts fill, drain and churn single stacks and mix traffic across all
// four. Every accepted request runs through a local model of the four stacks,
// and each strobed result is compared field by field with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import mstk_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 1830;
    localparam int MAX_GAP      = 14;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int PRINT_LIMIT  = 20;

    // traffic shapes for the random bursts
    typedef enum int {
        SEQ_FILL,
        SEQ_DRAIN,
        SEQ_MIXED,
        SEQ_CHURN
    } t_seq;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        t_status            status;
        logic               now_empty;
    } t_stack_result;

    typedef struct {
        t_kind              kind;
        logic [IDX_W-1:0]   idx;
        logic [VALUE_W-1:0] value;
        int unsigned        gap;
        bit                 typed;
        t_stack_result      result;
    } t_stim_row;

    // DUT connections, all inputs known from time zero
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                start         = 1'b0;
    logic [KIND_W-1:0]   i_kind        = '0;
    logic [IDX_W-1:0]    i_stack_index = '0;
    logic [VALUE_W-1:0]  i_push_value  = '0;
    logic                busy;
    logic                o_done;
    logic [VALUE_W-1:0]  o_read_value;
    logic [STATUS_W-1:0] o_status;
    logic                o_now_empty;

    // local copy of the four stacks
    logic [DATA_W-1:0] stack_words [NUM_STACKS][CAP];
    int unsigned       stack_fill  [NUM_STACKS] = '{default: 0};

    // outstanding predictions and bookkeeping
    t_stack_result  pending_results [$];
    t_stim_row      directed_rows   [$];
    bit             row_typed   = 1'b0;
    t_stack_result  row_result  = '0;
    int unsigned    n_accepted  = 0;
    int unsigned    n_results   = 0;
    int unsigned    n_mismatch  = 0;
    int unsigned    quiet_cycles = 0;
    int unsigned    kind_seen   [4] = '{default: 0};
    int unsigned    n_ok = 0, n_over = 0, n_under = 0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    partitioned_multi_stack u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_stack_index (i_stack_index),
        .i_push_value  (i_push_value),
        .o_done        (o_done),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_now_empty   (o_now_empty)
    );

    // apply one request to the local stacks and return its result
    function automatic t_stack_result apply_request(t_kind kind, logic [IDX_W-1:0] idx,
                                                    logic [VALUE_W-1:0] value);
        t_stack_result res;
        int unsigned   sel;
        int unsigned   cnt;
        res = '{read_value: '0, status: ST_OK, now_empty: 1'b1};
        sel = int'(idx);
        if (sel >= NUM_STACKS) begin
            // no such stack: nothing changes, reported as empty
            if (kind == KIND_PUSH) begin
                res.status = ST_OVER;
            end else if (kind == KIND_POP || kind == KIND_PEEK) begin
                res.status = ST_UNDER;
            end
        end else begin
            cnt = stack_fill[sel];
            case (kind)
                KIND_PUSH: begin
                    if (cnt < CAP) begin
                        stack_words[sel][cnt] = value[DATA_W-1:0];
                        cnt++;
                    end else begin
                        res.status = ST_OVER;
                    end
                end
                KIND_POP, KIND_PEEK: begin
                    if (cnt > 0) begin
                        res.read_value = VALUE_W'(stack_words[sel][cnt-1]);
                        if (kind == KIND_POP) cnt--;
                    end else begin
                        res.status = ST_UNDER;
                    end
                end
                default: begin
                end
            endcase
            stack_fill[sel] = cnt;
            res.now_empty   = (cnt == 0);
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                   logic [VALUE_W-1:0] want);
        if (n_mismatch < PRINT_LIMIT)
            $display("[%0t] mismatch at result %0d, %s: got %h, expected %h",
                     $time, n_results, what, got, want);
        n_mismatch++;
    endtask

    task automatic add_row(t_kind kind, logic [IDX_W-1:0] idx, logic [VALUE_W-1:0] value,
                           int unsigned gap, bit typed, logic [VALUE_W-1:0] rd,
                           t_status st, logic empty);
        t_stim_row row;
        row.kind   = kind;
        row.idx    = idx;
        row.value  = value;
        row.gap    = gap;
        row.typed  = typed;
        row.result = '{read_value: rd, status: st, now_empty: empty};
        directed_rows.push_back(row);
    endtask

    // present one item at a falling edge and hold it until it is taken
    task automatic drive_item(t_kind kind, logic [IDX_W-1:0] idx, logic [VALUE_W-1:0] value,
                              int unsigned gap, bit typed, t_stack_result result);
        int unsigned seen;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        row_typed     = typed;
        row_result    = result;
        start         <= 1'b1;
        i_kind        <= kind;
        i_stack_index <= idx;
        i_push_value  <= value;
        seen = n_accepted;
        do @(negedge i_clk); while (n_accepted == seen);
    endtask

    // accept items, predict, and check strobed results
    always @(posedge i_clk) begin
        t_stack_result predicted;
        t_stack_result want;
        if (i_rst_n) begin
            quiet_cycles++;
            if (start && !busy) begin
                predicted = apply_request(t_kind'(i_kind), i_stack_index, i_push_value);
                pending_results.push_back(row_typed ? row_result : predicted);
                kind_seen[i_kind]++;
                case (predicted.status)
                    ST_OVER:  n_over++;
                    ST_UNDER: n_under++;
                    default:  n_ok++;
                endcase
                n_accepted++;
                quiet_cycles = 0;
            end
            if (o_done === 1'b1) begin
                quiet_cycles = 0;
                n_results++;
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no item outstanding", o_read_value, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_read_value !== want.read_value)
                        report_mismatch("read_value", o_read_value, want.read_value);
                    if (o_status !== want.status)
                        report_mismatch("status", VALUE_W'(o_status), VALUE_W'(want.status));
                    if (o_now_empty !== want.now_empty)
                        report_mismatch("now_empty", VALUE_W'(o_now_empty),
                                        VALUE_W'(want.now_empty));
                end
            end
        end
    end

    // watchdog: nothing moving for too long ends the run
    initial begin
        while (quiet_cycles < STALL_LIMIT) @(negedge i_clk);
        $display("[%0t] no item or result for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus
    initial begin
        int unsigned        burst_left;
        t_seq               seq;
        int unsigned        target;
        int unsigned        idle_style;
        int unsigned        roll;
        int unsigned        gap;
        t_kind              kind;
        logic [IDX_W-1:0]   idx;
        logic [VALUE_W-1:0] value;

        burst_left = 0;
        seq        = SEQ_MIXED;
        target     = 0;
        idle_style = 0;

        // directed table: empty reads, no-ops, extreme words, back-to-back reuse
        add_row(KIND_POP,  2'd0, '0,            0, 1'b1, '0,            ST_UNDER, 1'b1);
        add_row(KIND_PEEK, 2'd1, '0,            1, 1'b1, '0,            ST_UNDER, 1'b1);
        add_row(KIND_POP,  2'd2, '1,            0, 1'b1, '0,            ST_UNDER, 1'b1);
        add_row(KIND_PEEK, 2'd3, '0,            0, 1'b1, '0,            ST_UNDER, 1'b1);
        add_row(KIND_NONE, 2'd2, '1,            2, 1'b1, '0,            ST_OK,    1'b1);
        add_row(KIND_PUSH, 2'd0, '0,            0, 1'b1, '0,            ST_OK,    1'b0);
        add_row(KIND_PEEK, 2'd0, '0,            0, 1'b1, '0,            ST_OK,    1'b0);
        add_row(KIND_PUSH, 2'd3, '1,            0, 1'b1, '0,            ST_OK,    1'b0);
        add_row(KIND_PEEK, 2'd3, '0,            0, 1'b1, '1,            ST_OK,    1'b0);
        add_row(KIND_NONE, 2'd3, '1,            0, 1'b1, '0,            ST_OK,    1'b0);
        add_row(KIND_POP,  2'd3, '0,            0, 1'b1, '1,            ST_OK,    1'b1);
        add_row(KIND_POP,  2'd3, '0,            0, 1'b1, '0,            ST_UNDER, 1'b1);
        add_row(KIND_PUSH, 2'd1, 32'hA5A5_5A5A, 0, 1'b0, '0,            ST_OK,    1'b0);
        add_row(KIND_PUSH, 2'd1, 32'h5A5A_A5A5, 0, 1'b0, '0,            ST_OK,    1'b0);
        add_row(KIND_PUSH, 2'd2, 32'h1234_5678, 0, 1'b0, '0,            ST_OK,    1'b0);
        add_row(KIND_POP,  2'd1, '0,            0, 1'b0, '0,            ST_OK,    1'b0);
        add_row(KIND_PEEK, 2'd1, '0,            0, 1'b0, '0,            ST_OK,    1'b0);
        add_row(KIND_POP,  2'd1, '0,            1, 1'b0, '0,            ST_OK,    1'b0);
        add_row(KIND_PEEK, 2'd1, '0,            0, 1'b1, '0,            ST_UNDER, 1'b1);
        add_row(KIND_POP,  2'd2, 32'hDEAD_BEEF, 0, 1'b0, '0,            ST_OK,    1'b0);
        add_row(KIND_PUSH, 2'd0, 32'h8000_0001, 3, 1'b0, '0,            ST_OK,    1'b0);
        add_row(KIND_POP,  2'd0, '0,            0, 1'b0, '0,            ST_OK,    1'b0);
        add_row(KIND_POP,  2'd0, '0,            0, 1'b1, '0,            ST_OK,    1'b1);
        add_row(KIND_NONE, 2'd0, '0,            0, 1'b1, '0,            ST_OK,    1'b1);

        // hold reset, then release on a falling edge
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            drive_item(directed_rows[r].kind, directed_rows[r].idx, directed_rows[r].value,
                       directed_rows[r].gap, directed_rows[r].typed, directed_rows[r].result);

        // random bursts, each with its own traffic shape and idling style
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(20, 90);
                seq        = t_seq'($urandom_range(0, 3));
                target     = $urandom_range(0, NUM_STACKS - 1);
                idle_style = $urandom_range(0, 2);
            end
            burst_left--;

            roll = $urandom_range(0, 99);
            case (seq)
                SEQ_FILL: begin
                    kind = (roll < 85) ? KIND_PUSH : t_kind'($urandom_range(0, 3));
                end
                SEQ_DRAIN: begin
                    if (roll < 65)      kind = KIND_POP;
                    else if (roll < 85) kind = KIND_PEEK;
                    else if (roll < 92) kind = KIND_NONE;
                    else                kind = KIND_PUSH;
                end
                SEQ_CHURN: begin
                    if (roll < 20)      kind = KIND_PEEK;
                    else                kind = (n % 2) ? KIND_POP : KIND_PUSH;
                end
                default: begin
                    if (roll < 35)      kind = KIND_PUSH;
                    else if (roll < 65) kind = KIND_POP;
                    else if (roll < 90) kind = KIND_PEEK;
                    else                kind = KIND_NONE;
                end
            endcase

            if (seq == SEQ_MIXED || $urandom_range(0, 9) == 0)
                idx = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
            else
                idx = IDX_W'(target);

            roll = $urandom_range(0, 15);
            if (roll == 0)      value = '0;
            else if (roll == 1) value = '1;
            else                value = VALUE_W'($urandom);

            case (idle_style)
                0:       gap = 0;
                1:       gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
                default: gap = $urandom_range(0, MAX_GAP);
            endcase

            drive_item(kind, idx, value, gap, 1'b0, '0);
        end
        start <= 1'b0;

        // let outstanding results arrive, then watch for strays
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never arrived", VALUE_W'(pending_results.size()), '0);

        $display("Run covered %0d items (%0d push, %0d pop, %0d peek, %0d no-op), %0d results.",
                 n_accepted, kind_seen[KIND_PUSH], kind_seen[KIND_POP], kind_seen[KIND_PEEK],
                 kind_seen[KIND_NONE], n_results);
        $display("Outcomes: %0d ok, %0d overflow, %0d underflow; %0d mismatches.",
                 n_ok, n_over, n_under, n_mismatch);
        if (n_mismatch == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
